// ===== rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module in rtl/.
package u8d_pkg;

  localparam int unsigned CpWidth   = 31;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned PendWidth = 3;

  // Output queue: two free slots needed to take a byte (one byte may give two results).
  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqPtrW  = $clog2(OutqDepth);
  localparam int unsigned OutqCntW  = $clog2(OutqDepth + 1);

  localparam logic [CpWidth-1:0] ReplChar = CpWidth'(8'h3F);

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [PendWidth-1:0] pending;
    logic [CpWidth-1:0]   partial;
    logic                 skipping;
  } dec_state_t;

  // One decoded result.
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               replaced;
    logic               last_of_run;
  } dec_result_t;

  // What one byte produces: zero to two results, oldest in res0.
  typedef struct packed {
    logic [1:0]  count;
    dec_result_t res0;
    dec_result_t res1;
  } dec_out_t;

endpackage

// ===== rtl/u8d_decode.sv =====
// Combinational one-byte step of the decoder: next state and results.
// Depends on u8d_pkg.
module u8d_decode import u8d_pkg::*; (
  input  dec_state_t           state_i,
  input  logic [ByteWidth-1:0] byte_i,
  output dec_state_t           state_o,
  output dec_out_t             out_o
);

  logic                 cont;
  logic                 do_lead;
  logic                 pre_vld;
  logic                 lead_vld;
  logic [CpWidth-1:0]   lead_cp;
  logic                 lead_repl;
  logic [CpWidth-1:0]   acc;
  logic [PendWidth-1:0] pend_dec;
  dec_state_t           st;

  assign cont     = (byte_i[7:6] == 2'b10);
  assign acc      = {state_i.partial[CpWidth-7:0], byte_i[5:0]};
  assign pend_dec = state_i.pending - PendWidth'(1);

  always_comb begin
    st        = state_i;
    do_lead   = 1'b0;
    pre_vld   = 1'b0;
    lead_vld  = 1'b0;
    lead_cp   = '0;
    lead_repl = 1'b0;

    if (state_i.pending != '0) begin
      if (cont) begin
        st.pending = pend_dec;
        if (pend_dec == '0) begin
          // sequence complete
          lead_vld   = 1'b1;
          lead_cp    = acc;
          st.partial = '0;
        end else begin
          st.partial = acc;
        end
      end else begin
        // broken sequence: replace, then treat byte as a new lead
        pre_vld    = 1'b1;
        st.pending = '0;
        st.partial = '0;
        do_lead    = 1'b1;
      end
    end else if (state_i.skipping) begin
      if (!cont) begin
        st.skipping = 1'b0;
        do_lead     = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (cont) begin
        lead_vld    = 1'b1;
        lead_cp     = ReplChar;
        lead_repl   = 1'b1;
        st.skipping = 1'b1;
      end else if (byte_i[7] == 1'b0) begin
        lead_vld = 1'b1;
        lead_cp  = CpWidth'(byte_i);
      end else if (byte_i[7:5] == 3'b110) begin
        st.partial = CpWidth'(byte_i[4:0]);
        st.pending = PendWidth'(1);
      end else if (byte_i[7:4] == 4'b1110) begin
        st.partial = CpWidth'(byte_i[3:0]);
        st.pending = PendWidth'(2);
      end else if (byte_i[7:3] == 5'b11110) begin
        st.partial = CpWidth'(byte_i[2:0]);
        st.pending = PendWidth'(3);
      end else if (byte_i[7:2] == 6'b111110) begin
        st.partial = CpWidth'(byte_i[1:0]);
        st.pending = PendWidth'(4);
      end else begin
        // 0xFC-0xFF: one payload bit keeps the result inside 31 bits
        st.partial = CpWidth'(byte_i[0]);
        st.pending = PendWidth'(5);
      end
    end
  end

  always_comb begin
    out_o      = '0;
    out_o.res1 = '{code_point: lead_cp, replaced: lead_repl, last_of_run: 1'b1};
    if (pre_vld) begin
      out_o.res0  = '{code_point: ReplChar, replaced: 1'b1, last_of_run: !lead_vld};
      out_o.count = lead_vld ? 2'd2 : 2'd1;
    end else begin
      out_o.res0  = out_o.res1;
      out_o.count = lead_vld ? 2'd1 : 2'd0;
    end
  end

  assign state_o = st;

endmodule

// ===== rtl/u8d_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on u8d_pkg.
module u8d_outq import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  dec_out_t    push_data_i,
  output logic        room_o,
  output logic        valid_o,
  input  logic        ready_i,
  output dec_result_t data_o
);

  dec_result_t             mem_q [OutqDepth];
  logic [OutqPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [OutqPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [OutqCntW-1:0]     cnt_q, cnt_d;
  logic [OutqPtrW-1:0]     wr_ptr_nxt;
  logic [1:0]              n_push;
  logic                    pop;

  assign n_push     = push_i ? push_data_i.count : 2'd0;
  assign pop        = valid_o && ready_i;
  assign wr_ptr_nxt = wr_ptr_q + OutqPtrW'(1);

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= OutqCntW'(OutqDepth - 2));
  assign data_o  = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + OutqPtrW'(n_push);
  assign rd_ptr_d = rd_ptr_q + OutqPtrW'(pop);
  assign cnt_d    = cnt_q + OutqCntW'(n_push) - OutqCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i.res0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_data_i.res1;
    end
  end

endmodule

// ===== rtl/utf8_stream_decoder_core.sv =====
// Top level of the byte-serial UTF-8 decoder (legacy 1 to 6 byte forms).
// Depends on u8d_pkg, u8d_decode and u8d_outq.
//
// Usage:
//   Slave channel takes one raw byte per transfer on s_axis_tdata_i.
//   Master channel gives one decoded code point per transfer: tdata holds
//   the 31-bit code point, tuser flags a '?' replacement for malformed
//   input, tlast marks the final result caused by one input byte.
//   A byte gives zero, one or two results (two when a sequence is broken
//   by an ASCII byte: '?' first with tlast low, then the ASCII character).
// With the queue empty, a result is offered on the master side in the cycle
//   after the byte's transfer.
// Throughput: one byte per cycle while the receiver takes every result and
//   each byte gives at most one result; bytes that give two results need two transfers on the master side.
//   The rate is set by the four-entry result queue, which accepts a byte
//   only with two free entries.
// Stall: with the receiver stalled the queue fills, tready drops once three
//   results are buffered (up to four are held), and no result is lost.
// Reset: clears the decoder state (no open sequence, not skipping) and
//   empties the result queue; tready is high right after reset.
module utf8_stream_decoder_core import u8d_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Byte input
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [ByteWidth-1:0] s_axis_tdata_i,   // [7:0] in_byte
  // Decoded output
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,   // [30:0] code_point, [31] zero pad
  output logic                 m_axis_tuser_o,   // [0] replaced
  output logic                 m_axis_tlast_o    // last_of_run
);

  dec_state_t  state_q, state_d;
  dec_out_t    dec_out;
  dec_result_t head;
  logic        in_xfer;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // Next-state and result logic for the current byte.
  u8d_decode u_decode (
    .state_i (state_q),
    .byte_i  (s_axis_tdata_i),
    .state_o (state_d),
    .out_o   (dec_out)
  );

  // Decoder state advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Result queue decouples the two sides.
  u8d_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i (dec_out),
    .room_o      (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (head)
  );

  assign m_axis_tdata_o = {1'b0, head.code_point};
  assign m_axis_tuser_o = head.replaced;
  assign m_axis_tlast_o = head.last_of_run;

endmodule
